// ===== hdl/steq_pkg.sv =====
// Shared types and constants of the sorted timed event queue.
package steq_pkg;

   localparam int CMD_W      = 2;
   localparam int KIND_W     = 3;
   localparam int TIME_W     = 64;
   localparam int LIS_PORT_W = 8;
   localparam int TAG_PORT_W = 32;
   localparam int LEFT_W     = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_RUN    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADDED    = 3'd0,
      KIND_REJECTED = 3'd1,
      KIND_FIRED    = 3'd2,
      KIND_NOTHING  = 3'd3,
      KIND_REMOVED  = 3'd4,
      KIND_CLEARED  = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CHK,
      ST_INS_PUT,
      ST_RUN_CHK,
      ST_RUN_END,
      ST_RM_CHK,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_LAST,
      CUR_ZERO,
      CUR_DEC,
      CUR_INC
   } cur_op_type;

   typedef enum logic [1:0] {
      HOLE_HOLD,
      HOLE_COUNT,
      HOLE_CUR
   } hole_op_type;

   typedef enum logic [1:0] {
      WR_SHIFT,
      WR_NEW,
      WR_CLR
   } wsel_type;

   typedef struct packed {
      logic        capture;
      cur_op_type  cur_op;
      hole_op_type hole_op;
      logic        we;
      wsel_type    wsel;
      logic        pop;
      logic        push;
      logic        clear;
      logic        pend_load;
      logic        pend_clr;
      logic        out_load;
      logic        out_pend;
      kind_type    out_kind;
      logic        out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic cur_zero;
      logic cur_last;
      logic rd_gt;
      logic rd_due;
      logic rd_lis_nz;
      logic rd_lis_match;
      logic pend_valid;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== hdl/sorted_timed_event_queue.sv =====
// Top level of the sorted timed event queue.
// Add: one queued entry shifted per cycle, tail first, until the new entry's slot is found.
// Run: one due head entry checked per cycle, unless a fired result waits to be emitted.
// Remove: one entry checked per cycle, a matching listener cleared to zero.
// One request in progress at a time; the result register frees the request side.
// Synchronous reset empties the queue at once; entry storage is not cleared.
module sorted_timed_event_queue #(
   parameter int CAPACITY      = 32,
   parameter int LISTENER_BITS = 8,
   parameter int TAG_BITS      = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [steq_pkg::CMD_W-1:0]       req_command,
   input  logic [steq_pkg::TIME_W-1:0]      req_time_value,
   input  logic [steq_pkg::LIS_PORT_W-1:0]  req_listener_id,
   input  logic [steq_pkg::TAG_PORT_W-1:0]  req_data_tag,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [steq_pkg::KIND_W-1:0]      rsp_kind,
   output logic [steq_pkg::LIS_PORT_W-1:0]  rsp_fired_listener,
   output logic [steq_pkg::TAG_PORT_W-1:0]  rsp_fired_tag,
   output logic [steq_pkg::TIME_W-1:0]      rsp_fired_time,
   output logic [steq_pkg::LEFT_W-1:0]      rsp_entries_left,
   output logic                             rsp_last
);

   steq_pkg::dp_cmd_type  dp_cmd;
   steq_pkg::dp_stat_type dp_stat;

   steq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .stat        (dp_stat),
      .cmd         (dp_cmd)
   );

   steq_dpath #(
      .CAPACITY      (CAPACITY),
      .LISTENER_BITS (LISTENER_BITS),
      .TAG_BITS      (TAG_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .stat               (dp_stat),
      .req_time_value     (req_time_value),
      .req_listener_id    (req_listener_id),
      .req_data_tag       (req_data_tag),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_fired_listener (rsp_fired_listener),
      .rsp_fired_tag      (rsp_fired_tag),
      .rsp_fired_time     (rsp_fired_time),
      .rsp_entries_left   (rsp_entries_left),
      .rsp_last           (rsp_last)
   );

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.out_load |-> dp_stat.out_free)
      else $error("result register overwritten before it was taken");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.pop |-> !dp_stat.empty)
      else $error("entry removed from an empty queue");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.push |-> !dp_stat.full)
      else $error("entry inserted into a full queue");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != steq_pkg::KIND_FIRED)) |-> rsp_last)
      else $error("non-fired result without last");
`endif

endmodule

// ===== hdl/steq_ram.sv =====
// Generic simple dual-port RAM with registered read.
module steq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/steq_ctrl.sv =====
// Controller state machine of the sorted timed event queue.
module steq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [steq_pkg::CMD_W-1:0]    req_command,
   output logic                          req_stall,
   input  steq_pkg::dp_stat_type         stat,
   output steq_pkg::dp_cmd_type          cmd
);

   steq_pkg::state_type state_ff, state_in;
   steq_pkg::kind_type  kind_ff, kind_in;
   steq_pkg::cmd_type   req_cmd;

   assign req_cmd   = steq_pkg::cmd_type'(req_command);
   assign req_stall = (state_ff != steq_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= steq_pkg::ST_IDLE;
         kind_ff  <= steq_pkg::KIND_ADDED;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         steq_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  steq_pkg::CMD_ADD: begin
                     if (stat.full) begin
                        state_in = steq_pkg::ST_EMIT;
                        kind_in  = steq_pkg::KIND_REJECTED;
                     end else if (stat.empty) begin
                        state_in = steq_pkg::ST_INS_PUT;
                     end else begin
                        state_in = steq_pkg::ST_INS_CHK;
                     end
                  end
                  steq_pkg::CMD_RUN: state_in = steq_pkg::ST_RUN_CHK;
                  steq_pkg::CMD_REMOVE: begin
                     if (stat.empty) begin
                        state_in = steq_pkg::ST_EMIT;
                        kind_in  = steq_pkg::KIND_REMOVED;
                     end else begin
                        state_in = steq_pkg::ST_RM_CHK;
                     end
                  end
                  steq_pkg::CMD_CLEAR: begin
                     state_in = steq_pkg::ST_EMIT;
                     kind_in  = steq_pkg::KIND_CLEARED;
                  end
               endcase
            end
         end
         steq_pkg::ST_INS_CHK: begin
            if (!stat.rd_gt || stat.cur_zero) begin
               state_in = steq_pkg::ST_INS_PUT;
            end
         end
         steq_pkg::ST_INS_PUT: begin
            state_in = steq_pkg::ST_EMIT;
            kind_in  = steq_pkg::KIND_ADDED;
         end
         steq_pkg::ST_RUN_CHK: begin
            if (!stat.rd_due) begin
               state_in = steq_pkg::ST_RUN_END;
            end
         end
         steq_pkg::ST_RUN_END: begin
            if (stat.out_free) begin
               state_in = steq_pkg::ST_IDLE;
            end
         end
         steq_pkg::ST_RM_CHK: begin
            if (stat.cur_last) begin
               state_in = steq_pkg::ST_EMIT;
               kind_in  = steq_pkg::KIND_REMOVED;
            end
         end
         steq_pkg::ST_EMIT: begin
            if (stat.out_free) begin
               state_in = steq_pkg::ST_IDLE;
            end
         end
         default: state_in = steq_pkg::ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd          = '0;
      cmd.cur_op   = steq_pkg::CUR_HOLD;
      cmd.hole_op  = steq_pkg::HOLE_HOLD;
      cmd.wsel     = steq_pkg::WR_SHIFT;
      cmd.out_kind = kind_ff;
      unique case (state_ff)
         steq_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (req_cmd)
                  steq_pkg::CMD_ADD: begin
                     cmd.cur_op  = steq_pkg::CUR_LAST;
                     cmd.hole_op = steq_pkg::HOLE_COUNT;
                  end
                  steq_pkg::CMD_RUN: begin
                     cmd.cur_op   = steq_pkg::CUR_ZERO;
                     cmd.pend_clr = 1'b1;
                  end
                  steq_pkg::CMD_REMOVE: cmd.cur_op = steq_pkg::CUR_ZERO;
                  steq_pkg::CMD_CLEAR:  cmd.clear  = 1'b1;
               endcase
            end
         end
         steq_pkg::ST_INS_CHK: begin
            if (stat.rd_gt) begin
               cmd.we      = 1'b1;
               cmd.wsel    = steq_pkg::WR_SHIFT;
               cmd.hole_op = steq_pkg::HOLE_CUR;
               if (!stat.cur_zero) begin
                  cmd.cur_op = steq_pkg::CUR_DEC;
               end
            end
         end
         steq_pkg::ST_INS_PUT: begin
            cmd.we   = 1'b1;
            cmd.wsel = steq_pkg::WR_NEW;
            cmd.push = 1'b1;
         end
         steq_pkg::ST_RUN_CHK: begin
            if (stat.rd_due) begin
               if (!stat.rd_lis_nz) begin
                  cmd.pop = 1'b1;
               end else if (!stat.pend_valid || stat.out_free) begin
                  cmd.out_load  = stat.pend_valid;
                  cmd.out_pend  = 1'b1;
                  cmd.out_last  = 1'b0;
                  cmd.pend_load = 1'b1;
                  cmd.pop       = 1'b1;
               end
            end
         end
         steq_pkg::ST_RUN_END: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_pend = stat.pend_valid;
               cmd.out_kind = steq_pkg::KIND_NOTHING;
               cmd.out_last = 1'b1;
            end
         end
         steq_pkg::ST_RM_CHK: begin
            cmd.we   = stat.rd_lis_match;
            cmd.wsel = steq_pkg::WR_CLR;
            if (!stat.cur_last) begin
               cmd.cur_op = steq_pkg::CUR_INC;
            end
         end
         steq_pkg::ST_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
            end
         end
         default: cmd.capture = 1'b0;
      endcase
   end

endmodule

// ===== hdl/steq_dpath.sv =====
// Datapath of the sorted timed event queue: ring storage, pointers, result register.
module steq_dpath #(
   parameter int CAPACITY      = 32,
   parameter int LISTENER_BITS = 8,
   parameter int TAG_BITS      = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  steq_pkg::dp_cmd_type               cmd,
   output steq_pkg::dp_stat_type              stat,
   input  logic [steq_pkg::TIME_W-1:0]        req_time_value,
   input  logic [steq_pkg::LIS_PORT_W-1:0]    req_listener_id,
   input  logic [steq_pkg::TAG_PORT_W-1:0]    req_data_tag,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [steq_pkg::KIND_W-1:0]        rsp_kind,
   output logic [steq_pkg::LIS_PORT_W-1:0]    rsp_fired_listener,
   output logic [steq_pkg::TAG_PORT_W-1:0]    rsp_fired_tag,
   output logic [steq_pkg::TIME_W-1:0]        rsp_fired_time,
   output logic [steq_pkg::LEFT_W-1:0]        rsp_entries_left,
   output logic                               rsp_last
);

   localparam int TIME_W     = steq_pkg::TIME_W;
   localparam int LIS_PORT_W = steq_pkg::LIS_PORT_W;
   localparam int TAG_PORT_W = steq_pkg::TAG_PORT_W;
   localparam int LEFT_W     = steq_pkg::LEFT_W;
   localparam int LIS_W  = (LISTENER_BITS < LIS_PORT_W) ? LISTENER_BITS : LIS_PORT_W;
   localparam int TAG_W  = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
   localparam int DATA_W = TIME_W + LIS_W + TAG_W;
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] hole_ff, hole_in;
   logic [CNT_W-1:0] count_m1;

   logic [TIME_W-1:0] tv_ff;
   logic [LIS_W-1:0]  lis_ff;
   logic [TAG_W-1:0]  tag_ff;

   logic              pend_valid_ff, pend_valid_in;
   logic [TIME_W-1:0] pend_time_ff;
   logic [LIS_W-1:0]  pend_lis_ff;
   logic [TAG_W-1:0]  pend_tag_ff;
   logic [CNT_W-1:0]  pend_left_ff;

   logic               out_valid_ff, out_valid_in;
   steq_pkg::kind_type out_kind_ff;
   logic [TIME_W-1:0]  out_time_ff;
   logic [LIS_W-1:0]   out_lis_ff;
   logic [TAG_W-1:0]   out_tag_ff;
   logic [CNT_W-1:0]   out_left_ff;
   logic               out_last_ff;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;
   logic [TIME_W-1:0] rd_time;
   logic [LIS_W-1:0]  rd_lis;
   logic [TAG_W-1:0]  rd_tag;

   // logical slot to physical address in the ring
   function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] offs,
                                                 input logic             plus1);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, offs} + (IDX_W+1)'(plus1);
      if (sum >= (IDX_W+1)'(CAPACITY)) begin
         sum = sum - (IDX_W+1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign count_m1 = count_ff - CNT_W'(1);

   assign rd_time = rd_data[DATA_W-1 -: TIME_W];
   assign rd_lis  = rd_data[TAG_W +: LIS_W];
   assign rd_tag  = rd_data[TAG_W-1:0];

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (cmd.pop) begin
         head_in  = (head_ff == IDX_W'(CAPACITY - 1)) ? '0 : head_ff + IDX_W'(1);
         count_in = count_m1;
      end else if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      unique case (cmd.cur_op)
         steq_pkg::CUR_HOLD: cur_in = cur_ff;
         steq_pkg::CUR_LAST: cur_in = count_m1[IDX_W-1:0];
         steq_pkg::CUR_ZERO: cur_in = '0;
         steq_pkg::CUR_DEC:  cur_in = cur_ff - IDX_W'(1);
         steq_pkg::CUR_INC:  cur_in = cur_ff + IDX_W'(1);
         default:            cur_in = cur_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.hole_op)
         steq_pkg::HOLE_HOLD:  hole_in = hole_ff;
         steq_pkg::HOLE_COUNT: hole_in = count_ff[IDX_W-1:0];
         steq_pkg::HOLE_CUR:   hole_in = cur_ff;
         default:              hole_in = hole_ff;
      endcase
   end

   // read address follows the next pointers so that rd_data matches cur_ff
   assign rd_addr = ring_addr(head_in, cur_in, 1'b0);
   assign wr_en   = cmd.we;

   always_comb begin
      unique case (cmd.wsel)
         steq_pkg::WR_SHIFT: begin
            wr_addr = ring_addr(head_ff, cur_ff, 1'b1);
            wr_data = rd_data;
         end
         steq_pkg::WR_NEW: begin
            wr_addr = ring_addr(head_ff, hole_ff, 1'b0);
            wr_data = {tv_ff, lis_ff, tag_ff};
         end
         steq_pkg::WR_CLR: begin
            wr_addr = ring_addr(head_ff, cur_ff, 1'b0);
            wr_data = {rd_time, {LIS_W{1'b0}}, rd_tag};
         end
         default: begin
            wr_addr = ring_addr(head_ff, cur_ff, 1'b0);
            wr_data = rd_data;
         end
      endcase
   end

   steq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (cmd.pend_clr) begin
         pend_valid_in = 1'b0;
      end else if (cmd.pend_load) begin
         pend_valid_in = 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         cur_ff        <= '0;
         hole_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         cur_ff        <= cur_in;
         hole_ff       <= hole_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tv_ff  <= req_time_value;
         lis_ff <= req_listener_id[LIS_W-1:0];
         tag_ff <= req_data_tag[TAG_W-1:0];
      end
      if (cmd.pend_load) begin
         pend_time_ff <= rd_time;
         pend_lis_ff  <= rd_lis;
         pend_tag_ff  <= rd_tag;
         pend_left_ff <= count_m1;
      end
      if (cmd.out_load) begin
         out_last_ff <= cmd.out_last;
         if (cmd.out_pend) begin
            out_kind_ff <= steq_pkg::KIND_FIRED;
            out_time_ff <= pend_time_ff;
            out_lis_ff  <= pend_lis_ff;
            out_tag_ff  <= pend_tag_ff;
            out_left_ff <= pend_left_ff;
         end else begin
            out_kind_ff <= cmd.out_kind;
            out_time_ff <= '0;
            out_lis_ff  <= '0;
            out_tag_ff  <= '0;
            out_left_ff <= count_ff;
         end
      end
   end

   assign stat.full         = (count_ff == CNT_W'(CAPACITY));
   assign stat.empty        = (count_ff == '0);
   assign stat.cur_zero     = (cur_ff == '0);
   assign stat.cur_last     = (CNT_W'(cur_ff) == count_m1);
   assign stat.rd_gt        = (rd_time > tv_ff);
   assign stat.rd_due       = (count_ff != '0) && (rd_time <= tv_ff);
   assign stat.rd_lis_nz    = (rd_lis != '0);
   assign stat.rd_lis_match = (rd_lis == lis_ff);
   assign stat.pend_valid   = pend_valid_ff;
   assign stat.out_free     = !out_valid_ff || !rsp_stall;

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_fired_listener = LIS_PORT_W'(out_lis_ff);
   assign rsp_fired_tag      = TAG_PORT_W'(out_tag_ff);
   assign rsp_fired_time     = out_time_ff;
   assign rsp_entries_left   = LEFT_W'(out_left_ff);
   assign rsp_last           = out_last_ff;

endmodule

// ===== tb/steq_checker.sv =====
`timescale 1ns / 1ps
// Checker of the sorted timed event queue: tracks the queue contents and compares each result.
module steq_checker #(
   parameter int CAPACITY = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [steq_pkg::CMD_W-1:0]        req_command,
   input  logic [steq_pkg::TIME_W-1:0]       req_time_value,
   input  logic [steq_pkg::LIS_PORT_W-1:0]   req_listener_id,
   input  logic [steq_pkg::TAG_PORT_W-1:0]   req_data_tag,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [steq_pkg::KIND_W-1:0]       rsp_kind,
   input  logic [steq_pkg::LIS_PORT_W-1:0]   rsp_fired_listener,
   input  logic [steq_pkg::TAG_PORT_W-1:0]   rsp_fired_tag,
   input  logic [steq_pkg::TIME_W-1:0]       rsp_fired_time,
   input  logic [steq_pkg::LEFT_W-1:0]       rsp_entries_left,
   input  logic                              rsp_last,
   output int                                mismatches,
   output int                                outstanding
);

   typedef struct packed {
      steq_pkg::kind_type                kind;
      logic [steq_pkg::LIS_PORT_W-1:0]   lis;
      logic [steq_pkg::TAG_PORT_W-1:0]   tag;
      logic [steq_pkg::TIME_W-1:0]       tm;
      logic [steq_pkg::LEFT_W-1:0]       left;
      logic                              last;
   } queue_answer_type;

   logic [steq_pkg::TIME_W-1:0]     slot_time [CAPACITY];
   logic [steq_pkg::LIS_PORT_W-1:0] slot_lis  [CAPACITY];
   logic [steq_pkg::TAG_PORT_W-1:0] slot_tag  [CAPACITY];
   int                              slot_count;
   queue_answer_type                answer_fifo [$];

   function automatic queue_answer_type plain_answer(steq_pkg::kind_type kind, int left);
      queue_answer_type a;
      a = '0;
      a.kind = kind;
      a.left = steq_pkg::LEFT_W'(left);
      a.last = 1'b1;
      return a;
   endfunction

   task automatic step_event_queue(steq_pkg::cmd_type op,
                                   logic [steq_pkg::TIME_W-1:0] tv,
                                   logic [steq_pkg::LIS_PORT_W-1:0] lis,
                                   logic [steq_pkg::TAG_PORT_W-1:0] tag);
      int               pos;
      int               due;
      int               i;
      bit               have;
      queue_answer_type held;
      case (op)
         steq_pkg::CMD_ADD: begin
            if (slot_count >= CAPACITY) begin
               answer_fifo.push_back(plain_answer(steq_pkg::KIND_REJECTED, slot_count));
            end else begin
               pos = 0;
               while (pos < slot_count && slot_time[pos] <= tv) pos++;
               for (i = slot_count; i > pos; i--) begin
                  slot_time[i] = slot_time[i-1];
                  slot_lis[i]  = slot_lis[i-1];
                  slot_tag[i]  = slot_tag[i-1];
               end
               slot_time[pos] = tv;
               slot_lis[pos]  = lis;
               slot_tag[pos]  = tag;
               slot_count++;
               answer_fifo.push_back(plain_answer(steq_pkg::KIND_ADDED, slot_count));
            end
         end
         steq_pkg::CMD_RUN: begin
            due  = 0;
            have = 1'b0;
            held = '0;
            while (due < slot_count && slot_time[due] <= tv) begin
               if (slot_lis[due] != '0) begin
                  if (have) answer_fifo.push_back(held);
                  held.kind = steq_pkg::KIND_FIRED;
                  held.lis  = slot_lis[due];
                  held.tag  = slot_tag[due];
                  held.tm   = slot_time[due];
                  held.left = steq_pkg::LEFT_W'(slot_count - due - 1);
                  held.last = 1'b0;
                  have = 1'b1;
               end
               due++;
            end
            for (i = due; i < slot_count; i++) begin
               slot_time[i-due] = slot_time[i];
               slot_lis[i-due]  = slot_lis[i];
               slot_tag[i-due]  = slot_tag[i];
            end
            slot_count -= due;
            if (have) begin
               held.last = 1'b1;
               answer_fifo.push_back(held);
            end else begin
               answer_fifo.push_back(plain_answer(steq_pkg::KIND_NOTHING, slot_count));
            end
         end
         steq_pkg::CMD_REMOVE: begin
            for (i = 0; i < slot_count; i++)
               if (slot_lis[i] == lis) slot_lis[i] = '0;
            answer_fifo.push_back(plain_answer(steq_pkg::KIND_REMOVED, slot_count));
         end
         default: begin
            slot_count = 0;
            answer_fifo.push_back(plain_answer(steq_pkg::KIND_CLEARED, 0));
         end
      endcase
   endtask

   function automatic int field_differs(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      queue_answer_type want;
      if (reset) begin
         slot_count = 0;
         answer_fifo.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answer_fifo.size() == 0) begin
               $error("unexpected result: kind %0d, listener %0h, tag %0h",
                      rsp_kind, rsp_fired_listener, rsp_fired_tag);
               mismatches++;
            end else begin
               want = answer_fifo.pop_front();
               mismatches += field_differs("kind", want.kind, rsp_kind);
               mismatches += field_differs("fired_listener", want.lis, rsp_fired_listener);
               mismatches += field_differs("fired_tag", want.tag, rsp_fired_tag);
               mismatches += field_differs("fired_time", want.tm, rsp_fired_time);
               mismatches += field_differs("entries_left", want.left, rsp_entries_left);
               mismatches += field_differs("last", want.last, rsp_last);
            end
         end
         if (req_valid && !req_stall)
            step_event_queue(steq_pkg::cmd_type'(req_command), req_time_value,
                             req_listener_id, req_data_tag);
      end
      outstanding = answer_fifo.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the sorted timed event queue.
module testbench;

   localparam int CAPACITY   = 32;
   localparam int RANDOM_REQ = 430;
   localparam int LIMIT      = 400000;
   localparam int LIS_W      = steq_pkg::LIS_PORT_W;
   localparam int TAG_W      = steq_pkg::TAG_PORT_W;
   localparam int TIME_W     = steq_pkg::TIME_W;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [steq_pkg::CMD_W-1:0]   req_command = steq_pkg::CMD_ADD;
   logic [TIME_W-1:0]            req_time_value = '0;
   logic [LIS_W-1:0]             req_listener_id = '0;
   logic [TAG_W-1:0]             req_data_tag = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [steq_pkg::KIND_W-1:0]  rsp_kind;
   logic [LIS_W-1:0]             rsp_fired_listener;
   logic [TAG_W-1:0]             rsp_fired_tag;
   logic [TIME_W-1:0]            rsp_fired_time;
   logic [steq_pkg::LEFT_W-1:0]  rsp_entries_left;
   logic                         rsp_last;

   int                    mismatches;
   int                    outstanding;
   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;
   int                    issued = 0;
   int unsigned           cycles = 0;
   logic [TIME_W-1:0]     sched_now = '0;

   sorted_timed_event_queue #(.CAPACITY(CAPACITY)) uut (.*);

   steq_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // entered and left at a falling edge; valid stays high for the caller
   task automatic offer_request(steq_pkg::cmd_type op, logic [TIME_W-1:0] tv,
                                logic [LIS_W-1:0] lis, logic [TAG_W-1:0] tag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_command     = op;
      req_time_value  = tv;
      req_listener_id = lis;
      req_data_tag    = tag;
      do @(posedge clock); while (req_stall);
      issued++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   function automatic logic [LIS_W-1:0] pick_listener();
      if ($urandom_range(9) < 7) return LIS_W'($urandom_range(0, 5));
      return LIS_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [TIME_W-1:0] any_time();
      return {$urandom, $urandom};
   endfunction

   task automatic fill_and_flush();
      logic [TIME_W-1:0] base;
      int                n;
      base = ($urandom_range(3) == 0) ? 64'hFFFF_FFFF_FFFF_FFC0 : any_time();
      n = CAPACITY + $urandom_range(1, 3);
      repeat (n)
         offer_request(steq_pkg::CMD_ADD, base + $urandom_range(0, 20), pick_listener(),
                       $urandom);
      if ($urandom_range(1))
         offer_request(steq_pkg::CMD_REMOVE, '0, pick_listener(), $urandom);
      if ($urandom_range(1))
         offer_request(steq_pkg::CMD_RUN, base + $urandom_range(0, 25), '0, $urandom);
      offer_request(steq_pkg::CMD_RUN, ($urandom_range(3) == 0) ? '1 : base + 30, '0,
                    $urandom);
   endtask

   task automatic mixed_traffic();
      int n;
      int r;
      n = $urandom_range(2, 10);
      if ($urandom_range(7) == 0)
         sched_now = ($urandom_range(1)) ? any_time() : 64'hFFFF_FFFF_FFFF_FF00;
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 50) begin
            offer_request(steq_pkg::CMD_ADD, sched_now + $urandom_range(0, 50),
                          pick_listener(), $urandom);
         end else if (r < 75) begin
            sched_now += $urandom_range(0, 30);
            offer_request(steq_pkg::CMD_RUN, sched_now, pick_listener(), $urandom);
         end else if (r < 90) begin
            offer_request(steq_pkg::CMD_REMOVE, any_time(), pick_listener(), $urandom);
         end else if (r < 95) begin
            offer_request(steq_pkg::CMD_CLEAR, any_time(), pick_listener(), $urandom);
         end else begin
            offer_request(steq_pkg::cmd_type'($urandom_range(0, 3)), any_time(),
                          pick_listener(), $urandom);
         end
      end
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(1, 4))
         offer_request(steq_pkg::cmd_type'($urandom_range(0, 3)), any_time(),
                       LIS_W'($urandom_range(0, 255)), $urandom);
   endtask

   initial begin
      int send_pct [4];
      int recv_pct [4];
      int seq_no;
      int phase;
      int r;
      int waited;

      send_pct = '{0, 59, 0, 21};
      recv_pct = '{0, 0, 59, 21};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty queue, ties, cancelled entries, extremes of time and fields
      offer_request(steq_pkg::CMD_RUN, '0, '0, '0);
      offer_request(steq_pkg::CMD_REMOVE, '0, '0, '0);
      offer_request(steq_pkg::CMD_CLEAR, '1, '1, '1);
      offer_request(steq_pkg::CMD_ADD, '1, 8'hFF, 32'hFFFF_FFFF);
      offer_request(steq_pkg::CMD_ADD, '0, 8'h01, '0);
      offer_request(steq_pkg::CMD_ADD, 64'd5, 8'h80, 32'h8000_0000);
      offer_request(steq_pkg::CMD_ADD, 64'd5, 8'h80, 32'h0000_0001);
      offer_request(steq_pkg::CMD_ADD, 64'd5, 8'h03, 32'h0000_0002);
      offer_request(steq_pkg::CMD_ADD, 64'd5, 8'h00, 32'h0000_0003);
      offer_request(steq_pkg::CMD_ADD, 64'd4, 8'h04, 32'h0000_0004);
      offer_request(steq_pkg::CMD_REMOVE, '0, 8'h80, '0);
      offer_request(steq_pkg::CMD_REMOVE, '0, 8'h00, '0);
      offer_request(steq_pkg::CMD_RUN, 64'd3, '0, '0);
      offer_request(steq_pkg::CMD_RUN, 64'd4, '0, '0);
      offer_request(steq_pkg::CMD_RUN, 64'd5, '0, '0);
      offer_request(steq_pkg::CMD_ADD, 64'd9, 8'h07, 32'h0000_0007);
      offer_request(steq_pkg::CMD_REMOVE, '0, 8'h07, '0);
      offer_request(steq_pkg::CMD_RUN, 64'd9, '0, '0);
      offer_request(steq_pkg::CMD_RUN, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0);
      offer_request(steq_pkg::CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFE, 8'h55, 32'h5555_AAAA);
      offer_request(steq_pkg::CMD_RUN, '1, 8'hAA, 32'hAAAA_5555);
      offer_request(steq_pkg::CMD_ADD, 64'd1, 8'h2A, 32'h1234_5678);
      offer_request(steq_pkg::CMD_CLEAR, '0, '0, '0);
      offer_request(steq_pkg::CMD_RUN, '1, '0, '0);
      drain_results();

      issued = 0;
      seq_no = 0;
      phase  = 0;
      while (issued < RANDOM_REQ) begin
         if (seq_no % 3 == 0) begin
            drain_results();
            send_idle_pct  = send_pct[phase % 4];
            recv_stall_pct = recv_pct[phase % 4];
            phase++;
         end
         r = $urandom_range(9);
         if (seq_no == 0 || r < 2) fill_and_flush();
         else if (r < 8) mixed_traffic();
         else noise_burst();
         seq_no++;
      end

      req_valid = 1'b0;
      waited = 0;
      while (outstanding != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (100) @(negedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         if (outstanding != 0) $error("%0d results never arrived", outstanding);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/steq_pkg.sv
hdl/steq_ram.sv
hdl/steq_ctrl.sv
hdl/steq_dpath.sv
hdl/sorted_timed_event_queue.sv
tb/steq_checker.sv
tb/testbench.sv
